[sv/wear_aware_free_block_manager_defines.svh]
// assertion macros shared by the checker of the free block manager
// depends on nothing; every property is sampled on clk_i and gated by rst_ni
`ifndef WEAR_AWARE_FREE_BLOCK_MANAGER_DEFINES_SVH
`define WEAR_AWARE_FREE_BLOCK_MANAGER_DEFINES_SVH

// implication checked every clock edge outside reset
`define WAFBM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// implication checked at the clock edge after the premise
`define WAFBM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/wafbm_pkg.sv]
// types, constants and codes of the free block manager
// used by the front, the back and the top level
package wafbm_pkg;

  localparam int BLOCKS     = 256;
  localparam int STREAMS    = 16;
  localparam int ERASE_BITS = 16;
  localparam int BLK_W      = $clog2(BLOCKS);
  localparam int IDX_W      = $clog2(BLOCKS + 1);
  localparam int STAMP_W    = 32;
  localparam int PEND_W     = 8;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    KIND_ALLOC     = 4'd0,
    KIND_RELEASE   = 4'd1,
    KIND_ERASE     = 4'd2,
    KIND_PROG_ISS  = 4'd3,
    KIND_PROG_DONE = 4'd4,
    KIND_READ_ISS  = 4'd5,
    KIND_READ_DONE = 4'd6,
    KIND_GC_START  = 4'd7,
    KIND_GC_END    = 4'd8,
    KIND_QUERY     = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    OP_ALLOC, OP_RELEASE, OP_ERASE, OP_PROG_ISS, OP_PROG_DONE,
    OP_READ_ISS, OP_READ_DONE, OP_GC_START, OP_GC_END, OP_QUERY, OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_READ, ST_UPDATE, ST_FINISH
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [BLK_W-1:0] blk;
    logic [3:0]       tag;
    logic             map;
    logic             wear;
  } cmd_t;

  typedef struct packed {
    logic [ERASE_BITS-1:0] erase;
    logic                  in_pool;
    logic [ERASE_BITS-1:0] key;
    logic [STAMP_W-1:0]    stamp;
    logic [3:0]            stream;
    logic                  map;
    logic [PEND_W-1:0]     prog;
    logic [PEND_W-1:0]     rd;
    logic                  gc;
  } rec_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       picked_block;
    logic [15:0]      erase_spread;
    logic             gc_active;
    logic             gc_allowed;
    logic             program_pending;
    logic [8:0]       free_count;
  } res_t;

endpackage

[sv/wafbm_if.sv]
// valid/ready channels of the free block manager: command words in, result words out
// depends on nothing
interface wafbm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] block_id;
  logic [3:0] stream_tag;
  logic       for_mapping;
  logic       wear_aware;

  modport source (output valid, kind, block_id, stream_tag, for_mapping, wear_aware,
                  input ready);
  modport sink (input valid, kind, block_id, stream_tag, for_mapping, wear_aware,
                output ready);
endinterface

interface wafbm_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  picked_block;
  logic [15:0] erase_spread;
  logic        gc_active;
  logic        gc_allowed;
  logic        program_pending;
  logic [8:0]  free_count;

  modport source (output valid, status, picked_block, erase_spread, gc_active,
                  gc_allowed, program_pending, free_count, input ready);
  modport sink (input valid, status, picked_block, erase_spread, gc_active,
                gc_allowed, program_pending, free_count, output ready);
endinterface

[sv/wafbm_front.sv]
// front end: takes command words, decodes the kind and queues them for the back end
// depends on wafbm_pkg
module wafbm_front import wafbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] kind_i,
  input  logic [7:0] block_id_i,
  input  logic [3:0] stream_tag_i,
  input  logic       for_mapping_i,
  input  logic       wear_aware_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  cmd_t              cmd_new;
  logic              push, pop;

  always_comb begin
    cmd_new.blk  = block_id_i[BLK_W-1:0];
    cmd_new.tag  = (32'(stream_tag_i) < STREAMS) ? stream_tag_i : 4'd0;
    cmd_new.map  = for_mapping_i;
    cmd_new.wear = wear_aware_i;
    unique case (kind_i)
      KIND_ALLOC:     cmd_new.op = OP_ALLOC;
      KIND_RELEASE:   cmd_new.op = OP_RELEASE;
      KIND_ERASE:     cmd_new.op = OP_ERASE;
      KIND_PROG_ISS:  cmd_new.op = OP_PROG_ISS;
      KIND_PROG_DONE: cmd_new.op = OP_PROG_DONE;
      KIND_READ_ISS:  cmd_new.op = OP_READ_ISS;
      KIND_READ_DONE: cmd_new.op = OP_READ_DONE;
      KIND_GC_START:  cmd_new.op = OP_GC_START;
      KIND_GC_END:    cmd_new.op = OP_GC_END;
      KIND_QUERY:     cmd_new.op = OP_QUERY;
      default:        cmd_new.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_new;
  end

endmodule

[sv/wafbm_back.sv]
// back end: block record memory, scan for allocation and query, record updates
// depends on wafbm_pkg
module wafbm_back import wafbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  rec_t mem [BLOCKS];
  rec_t rdata_q;
  logic [BLK_W-1:0] raddr, waddr;
  logic             we;
  rec_t             wdata;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pv_q, pv_d;
  logic [BLK_W-1:0] pidx_q, pidx_d;

  logic                  found_q, found_d;
  logic [BLK_W-1:0]      best_q, best_d;
  rec_t                  brec_q, brec_d;
  logic [ERASE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  rec_t                  trec_q, trec_d;

  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [IDX_W-1:0]   free_q, free_d;
  logic               ov_q, ov_d;
  res_t               res_q, res_d;
  rec_t               upd;
  logic               load;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    pv_d    = 1'b0;
    pidx_d  = pidx_q;
    found_d = found_q;
    best_d  = best_q;
    brec_d  = brec_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    trec_d  = trec_q;
    stamp_d = stamp_q;
    free_d  = free_q;
    ov_d    = ov_q && !res_ready_i;
    res_d   = res_q;
    raddr   = cmd_q.blk;
    waddr   = cmd_q.blk;
    we      = 1'b0;
    wdata   = rdata_q;
    upd     = rdata_q;
    load    = 1'b0;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we          = 1'b1;
        waddr       = idx_q[BLK_W-1:0];
        wdata       = '0;
        wdata.in_pool = 1'b1;
        wdata.stamp = STAMP_W'(idx_q);
        idx_d       = idx_q + 1'b1;
        if (idx_q == IDX_W'(BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          found_d = 1'b0;
          unique case (cmd_i.op)
            OP_ALLOC, OP_QUERY: state_d = ST_SCAN;
            OP_NONE:            state_d = ST_FINISH;
            default:            state_d = ST_READ;
          endcase
        end
      end
      ST_SCAN: begin
        raddr = idx_q[BLK_W-1:0];
        if (idx_q != IDX_W'(BLOCKS)) begin
          pv_d   = 1'b1;
          pidx_d = idx_q[BLK_W-1:0];
          idx_d  = idx_q + 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
        if (pv_q) begin
          if (cmd_q.op == OP_ALLOC) begin
            // smallest key first, earliest stamp on equal keys
            if (rdata_q.in_pool && (!found_q || rdata_q.key < brec_q.key ||
                (rdata_q.key == brec_q.key && rdata_q.stamp < brec_q.stamp))) begin
              found_d = 1'b1;
              best_d  = pidx_q;
              brec_d  = rdata_q;
            end
          end else begin
            if (pidx_q == '0 || rdata_q.erase < lo_q) begin
              lo_d   = rdata_q.erase;
              best_d = pidx_q;
            end
            if (pidx_q == '0 || rdata_q.erase > hi_q) hi_d = rdata_q.erase;
            if (pidx_q == cmd_q.blk) trec_d = rdata_q;
          end
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        case (cmd_q.op)
          OP_RELEASE: begin
            if (!rdata_q.in_pool) free_d = free_q + 1'b1;
            upd.in_pool = 1'b1;
            upd.key     = cmd_q.wear ? rdata_q.erase : '0;
            upd.stamp   = stamp_q;
            stamp_d     = stamp_q + 1'b1;
          end
          OP_ERASE: begin
            if (rdata_q.erase != '1) upd.erase = rdata_q.erase + 1'b1;
            upd.stream = '0;
            upd.map    = 1'b0;
          end
          OP_PROG_ISS:  if (rdata_q.prog != '1) upd.prog = rdata_q.prog + 1'b1;
          OP_PROG_DONE: if (rdata_q.prog != '0) upd.prog = rdata_q.prog - 1'b1;
          OP_READ_ISS:  if (rdata_q.rd != '1) upd.rd = rdata_q.rd + 1'b1;
          OP_READ_DONE: if (rdata_q.rd != '0) upd.rd = rdata_q.rd - 1'b1;
          OP_GC_START:  upd.gc = 1'b1;
          OP_GC_END:    upd.gc = 1'b0;
          default:      upd = rdata_q;
        endcase
        we      = 1'b1;
        wdata   = upd;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        res_d = '0;
        if (cmd_q.op == OP_ALLOC) begin
          res_d.status       = !found_q;
          res_d.picked_block = found_q ? 8'(best_q) : 8'd0;
        end else if (cmd_q.op == OP_QUERY) begin
          res_d.picked_block    = 8'(best_q);
          res_d.erase_spread    = 16'(hi_q - lo_q);
          res_d.gc_active       = trec_q.gc;
          res_d.gc_allowed      = (trec_q.prog == '0) && (trec_q.rd == '0);
          res_d.program_pending = (trec_q.prog != '0);
        end
        res_d.free_count = 9'(free_q);
        // wait here while the previous result has not been taken
        if (!ov_q || res_ready_i) begin
          load = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
          if (cmd_q.op == OP_ALLOC && found_q) begin
            free_d           = free_q - 1'b1;
            res_d.free_count = 9'(free_q - 1'b1);
            we               = 1'b1;
            waddr            = best_q;
            wdata            = brec_q;
            wdata.in_pool    = 1'b0;
            wdata.stream     = cmd_q.tag;
            wdata.map        = cmd_q.map;
          end
        end else begin
          res_d = res_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      stamp_q <= STAMP_W'(BLOCKS);
      free_q  <= IDX_W'(BLOCKS);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      stamp_q <= stamp_d;
      free_q  <= free_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pidx_q <= pidx_d;
    best_q <= best_d;
    brec_q <= brec_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    trec_q <= trec_d;
    if (load) res_q <= res_d;
  end

endmodule

[sv/wear_aware_free_block_manager.sv]
// Free block manager for one flash plane. After reset the block first writes every
// block record to its initial value; command words sent in that time wait in the
// front queue, four at most, and run once the records are ready. Allocation and
// query read all 256 records through the single read port of the record memory,
// one a cycle; every other kind does one read-modify-write of its block record,
// and a word of unknown kind reads no record. A four-word queue keeps accepting
// commands, until it is full, while the back end works or a result waits to be
// taken.
// top level; depends on wafbm_pkg, wafbm_if, wafbm_front and wafbm_back
module wear_aware_free_block_manager import wafbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  wafbm_in_if.sink    in_i,
  wafbm_out_if.source out_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  wafbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .kind_i        (in_i.kind),
    .block_id_i    (in_i.block_id),
    .stream_tag_i  (in_i.stream_tag),
    .for_mapping_i (in_i.for_mapping),
    .wear_aware_i  (in_i.wear_aware),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  wafbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.status          = res.status;
  assign out_o.picked_block    = res.picked_block;
  assign out_o.erase_spread    = res.erase_spread;
  assign out_o.gc_active       = res.gc_active;
  assign out_o.gc_allowed      = res.gc_allowed;
  assign out_o.program_pending = res.program_pending;
  assign out_o.free_count      = res.free_count;

endmodule

[sv/wafbm_checker.sv]
// port-level checks of the free block manager, bound to the top level
// depends on wear_aware_free_block_manager_defines.svh
`include "wear_aware_free_block_manager_defines.svh"

module wafbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       status_i,
  input logic [7:0] picked_block_i,
  input logic       gc_allowed_i,
  input logic       program_pending_i,
  input logic [8:0] free_count_i
);

  `WAFBM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result word dropped")
  `WAFBM_ASSERT_IMP(a_empty_pick, out_valid_i && status_i, picked_block_i == 8'd0, "empty pick")
  `WAFBM_ASSERT_IMP(a_empty_cnt, out_valid_i && status_i, free_count_i == 9'd0, "pool not empty")
  `WAFBM_ASSERT_IMP(a_gc_excl, out_valid_i, !(gc_allowed_i && program_pending_i), "gc flags clash")

endmodule

bind wear_aware_free_block_manager wafbm_checker u_wafbm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .picked_block_i    (out_o.picked_block),
  .gc_allowed_i      (out_o.gc_allowed),
  .program_pending_i (out_o.program_pending),
  .free_count_i      (out_o.free_count)
);
